// ----- sv/rcfs_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfs_pkg
// shared constants, codes and the highlight weight table of the column shader
// ----------------------------------------------------------------------------
package rcfs_pkg;

  localparam int unsigned SCREEN_HEIGHT = 600;
  localparam int unsigned HALF_ROWS     = SCREEN_HEIGHT / 2;
  localparam int unsigned DIVIDEND      = SCREEN_HEIGHT * 256;
  localparam int unsigned QW            = $clog2(DIVIDEND + 1);

  localparam int unsigned ROW_W   = 10;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned INC_W   = 11;
  localparam int unsigned WT_W    = 11;
  localparam int unsigned DEN_W   = 14;
  localparam int unsigned IN_W    = 64;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned USER_W  = 2;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned FOG_STEPS = 10;
  localparam int unsigned WT_ONE    = 1024;
  localparam int unsigned DEPTH_MAX = 65535;
  localparam int unsigned ROM_DEPTH = 1025;

  localparam longint unsigned ANGLE_PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_Q30      = 64'd1073741824;

  // taylor term divisors (2k)(2k+1) for k = 1..5
  localparam longint unsigned TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef enum logic [1:0] {
    REGION_WALL  = 2'd0,
    REGION_SKY   = 2'd1,
    REGION_FLOOR = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    REG_FOG_START     = 3'd0,
    REG_FOG_END       = 3'd1,
    REG_FOG_LIMIT     = 3'd2,
    REG_HAZE_RGB      = 3'd3,
    REG_HIGHLIGHT_RGB = 3'd4,
    REG_SKY_RGB       = 3'd5,
    REG_GROUND_RGB    = 3'd6
  } reg_idx_e;

  typedef logic [WT_W-1:0] hl_rom_t [ROM_DEPTH];

  // sqrt(sin(angle)) weight per incidence code, built at elaboration
  function automatic hl_rom_t hl_rom_build();
    hl_rom_t        rom;
    longint unsigned x, x2, s, t, v, acc, bit_w, r;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x  = (longint'(i) * ANGLE_PI_Q30) >> 11;
      x2 = (x * x) >> 30;
      s  = x;
      t  = x;
      for (int k = 1; k <= 5; k++) begin
        t = ((t * x2) >> 30) / TAYLOR_DIV[k-1];
        if (k[0]) s = s - t;
        else      s = s + t;
      end
      if (s > ONE_Q30) s = ONE_Q30;
      v     = s;
      acc   = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (v >= acc + bit_w) begin
          v   = v - (acc + bit_w);
          acc = (acc >> 1) + bit_w;
        end else begin
          acc = acc >> 1;
        end
        bit_w = bit_w >> 2;
      end
      r = (acc + 16) >> 5;
      if (r > WT_ONE) r = WT_ONE;
      rom[i] = WT_W'(r);
    end
    return rom;
  endfunction

  localparam hl_rom_t HL_ROM = hl_rom_build();

endpackage

// ----- sv/rcfs_div.sv -----
// ----------------------------------------------------------------------------
// rcfs_div
// pipelined restoring divider of the fixed screen constant by a depth word
// ----------------------------------------------------------------------------
module rcfs_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rcfs_pkg::DEPTH_W-1:0]  divisor_i,
  output logic [rcfs_pkg::QW-1:0]       quot_o
);
  import rcfs_pkg::*;

  localparam logic [QW-1:0] DVD_BITS = QW'(DIVIDEND);

  logic [DEPTH_W-1:0] rem_q [QW];
  logic [DEPTH_W-1:0] rem_d [QW];
  logic [DEPTH_W-1:0] dvs_q [QW];
  logic [DEPTH_W-1:0] dvs_d [QW];
  logic [QW-1:0]      quo_q [QW];
  logic [QW-1:0]      quo_d [QW];

  // one quotient bit per stage, msb first
  always_comb begin
    logic [DEPTH_W:0]   sh;
    logic [DEPTH_W-1:0] pr;
    logic [DEPTH_W-1:0] pd;
    logic [QW-1:0]      pq;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        pr = '0;
        pd = divisor_i;
        pq = '0;
      end else begin
        pr = rem_q[k-1];
        pd = dvs_q[k-1];
        pq = quo_q[k-1];
      end
      sh       = {pr, DVD_BITS[QW-1-k]};
      dvs_d[k] = pd;
      if (sh >= {1'b0, pd}) begin
        rem_d[k] = DEPTH_W'(sh - {1'b0, pd});
        quo_d[k] = {pq[QW-2:0], 1'b1};
      end else begin
        rem_d[k] = sh[DEPTH_W-1:0];
        quo_d[k] = {pq[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dvs_q <= dvs_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q[QW-1];

endmodule

// ----- sv/raycast_column_fog_shader_unit.sv -----
// ----------------------------------------------------------------------------
// raycast_column_fog_shader_unit
// shades one pixel of a raycast column: wall with highlight and fog, sky, floor
// ----------------------------------------------------------------------------
// takes one word per clock and gives one shaded pixel per clock while the
// output word is taken; each word passes 18 stages of restoring division
// (wall height and floor depth side by side), one stage for the wall band
// and region decision, one setup plus 10 stages of fog weight division, one
// stage that picks the fog weight and source colour, and the output register
// with the final blend. the whole pipe holds when the output word is not
// taken, so a stall drops and repeats nothing. registers sit on an apb port
// with pready tied high; write them only while no pixel is in flight.
module raycast_column_fog_shader_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // screen_row[9:0], hit_depth[25:10], hit_rgb[49:26], incidence[60:50], zero pad
  input  logic [rcfs_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_rgb[23:0]
  output logic [rcfs_pkg::OUT_W-1:0]    m_axis_tdata,
  // region[1:0]
  output logic [rcfs_pkg::USER_W-1:0]   m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcfs_pkg::ADDR_W-1:0]   paddr,
  input  logic [rcfs_pkg::DATA_W-1:0]   pwdata,
  output logic [rcfs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import rcfs_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [DEPTH_W-1:0] depth;
    logic [RGB_W-1:0]   hit;
    logic [INC_W-1:0]   inc;
    logic               den_neg;
    logic               den_zero;
  } a_t;

  typedef struct packed {
    region_e            region;
    logic [DEPTH_W-1:0] dfog;
    logic               no_fog;
    logic [RGB_W-1:0]   hit;
    logic [INC_W-1:0]   inc;
  } b_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]   rem;
    logic [FOG_STEPS-1:0] quo;
    logic [DEPTH_W-1:0]   span;
    logic                 full;
    logic                 zero;
    region_e              region;
    logic [RGB_W-1:0]     col;
    logic [WT_W-1:0]      wt;
    logic [INC_W-1:0]     inc;
  } c_t;

  typedef struct packed {
    region_e          region;
    logic [RGB_W-1:0] src;
    logic [WT_W-1:0]  fw;
  } d_t;

  // per channel (a*(1-w) + b*w), truncated
  function automatic logic [RGB_W-1:0] blend(input logic [RGB_W-1:0] a,
                                             input logic [RGB_W-1:0] b,
                                             input logic [WT_W-1:0]  w);
    logic [RGB_W-1:0] res;
    logic [WT_W-1:0]  wi;
    logic [18:0]      acc;
    wi = WT_W'(WT_ONE) - w;
    for (int c = 0; c < 3; c++) begin
      acc = 19'(a[8*c +: 8]) * 19'(wi) + 19'(b[8*c +: 8]) * 19'(w);
      res[8*c +: 8] = acc[17:10];
    end
    return res;
  endfunction

  // ---------------- configuration registers ----------------
  logic [DEPTH_W-1:0] fog_start_q, fog_end_q;
  logic [WT_W-1:0]    fog_limit_q;
  logic [RGB_W-1:0]   haze_q, highlight_q, sky_q, ground_q;
  logic               wr_en;
  reg_idx_e           wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fog_start_q <= DEPTH_W'(512);
      fog_end_q   <= DEPTH_W'(5120);
      fog_limit_q <= WT_W'(819);
      haze_q      <= RGB_W'(24'h87CEEB);
      highlight_q <= RGB_W'(24'hFFFFFF);
      sky_q       <= RGB_W'(24'h87CEEB);
      ground_q    <= RGB_W'(24'h202020);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_FOG_START:     fog_start_q <= pwdata[DEPTH_W-1:0];
        REG_FOG_END:       fog_end_q   <= pwdata[DEPTH_W-1:0];
        REG_FOG_LIMIT:     fog_limit_q <= pwdata[WT_W-1:0];
        REG_HAZE_RGB:      haze_q      <= pwdata[RGB_W-1:0];
        REG_HIGHLIGHT_RGB: highlight_q <= pwdata[RGB_W-1:0];
        REG_SKY_RGB:       sky_q       <= pwdata[RGB_W-1:0];
        REG_GROUND_RGB:    ground_q    <= pwdata[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_FOG_START:     prdata = DATA_W'(fog_start_q);
      REG_FOG_END:       prdata = DATA_W'(fog_end_q);
      REG_FOG_LIMIT:     prdata = DATA_W'(fog_limit_q);
      REG_HAZE_RGB:      prdata = DATA_W'(haze_q);
      REG_HIGHLIGHT_RGB: prdata = DATA_W'(highlight_q);
      REG_SKY_RGB:       prdata = DATA_W'(sky_q);
      REG_GROUND_RGB:    prdata = DATA_W'(ground_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline enable ----------------
  // every stage moves together; only a waiting output word holds the pipe
  logic en;
  logic m_vld_q;
  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- input unpack and divisor prep ----------------
  logic [ROW_W-1:0]        in_row;
  logic [DEPTH_W-1:0]      in_depth;
  logic [RGB_W-1:0]        in_hit;
  logic [INC_W-1:0]        in_inc;
  logic signed [DEN_W-1:0] den_in;
  logic [DEPTH_W-1:0]      wall_dvs, floor_dvs;

  assign in_row   = s_axis_tdata[0 +: ROW_W];
  assign in_depth = s_axis_tdata[ROW_W +: DEPTH_W];
  assign in_hit   = s_axis_tdata[ROW_W+DEPTH_W +: RGB_W];
  assign in_inc   = s_axis_tdata[ROW_W+DEPTH_W+RGB_W +: INC_W];

  // floor row distance below the horizon, doubled
  assign den_in    = signed'(DEN_W'({in_row, 1'b0})) - signed'(DEN_W'(SCREEN_HEIGHT));
  // zero depth saturates: dividing by one gives the full column height
  assign wall_dvs  = (in_depth == '0) ? DEPTH_W'(1) : in_depth;
  assign floor_dvs = (den_in > 0) ? DEPTH_W'(den_in) : DEPTH_W'(1);

  logic [QW-1:0] wall_h, floor_d;

  rcfs_div u_wall_div (
    .clk_i     (clk_i),
    .en_i      (en),
    .divisor_i (wall_dvs),
    .quot_o    (wall_h)
  );

  rcfs_div u_floor_div (
    .clk_i     (clk_i),
    .en_i      (en),
    .divisor_i (floor_dvs),
    .quot_o    (floor_d)
  );

  // ---------------- side data beside the dividers ----------------
  a_t            a_q [QW];
  logic [QW-1:0] a_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= '0;
    else if (en) a_vld_q <= {a_vld_q[QW-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= '{row: in_row, depth: in_depth, hit: in_hit, inc: in_inc,
                  den_neg: den_in < 0, den_zero: den_in == 0};
      for (int k = 1; k < QW; k++) a_q[k] <= a_q[k-1];
    end
  end

  // ---------------- wall band and region ----------------
  a_t                   a_last;
  logic signed [QW:0]   h_s, diff_s, q_s, hq_s, y_s;
  logic                 is_wall, is_sky;
  logic [DEPTH_W-1:0]   fd;
  b_t                   b_d, b_q;
  logic                 b_vld_q;

  assign a_last = a_q[QW-1];

  always_comb begin
    h_s    = signed'({1'b0, wall_h});
    diff_s = signed'((QW+1)'(SCREEN_HEIGHT)) - h_s;
    // halve with truncation toward zero
    q_s    = (diff_s + signed'((QW+1)'(diff_s[QW]))) >>> 1;
    hq_s   = h_s + q_s;
    y_s    = signed'((QW+1)'(a_last.row));
    is_wall = (y_s > q_s) && (y_s < hq_s);
    is_sky  = y_s < signed'((QW+1)'(HALF_ROWS));
    // centre row and far rows saturate the floor depth
    if (a_last.den_zero || floor_d > QW'(DEPTH_MAX)) fd = DEPTH_W'(DEPTH_MAX);
    else                                              fd = floor_d[DEPTH_W-1:0];
    b_d.hit = a_last.hit;
    b_d.inc = a_last.inc;
    if (is_wall) begin
      b_d.region = REGION_WALL;
      b_d.dfog   = a_last.depth;
      b_d.no_fog = 1'b0;
    end else if (is_sky) begin
      b_d.region = REGION_SKY;
      b_d.dfog   = fd;
      b_d.no_fog = 1'b1;
    end else begin
      b_d.region = REGION_FLOOR;
      b_d.dfog   = fd;
      // row just above centre on an odd screen height: no fog
      b_d.no_fog = a_last.den_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q[QW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) b_q <= b_d;
  end

  // ---------------- fog weight division, highlight blend alongside ----------
  c_t                   c_q [FOG_STEPS+1];
  c_t                   c_d [FOG_STEPS+1];
  logic [FOG_STEPS:0]   c_vld_q;

  always_comb begin
    logic [DEPTH_W-1:0] num;
    logic [DEPTH_W:0]   sh;
    logic [WT_W-1:0]    idx;
    num               = b_q.dfog - fog_start_q;
    c_d[0].rem        = num;
    c_d[0].quo        = '0;
    c_d[0].span       = fog_end_q - fog_start_q;
    c_d[0].zero       = b_q.no_fog || (b_q.dfog <= fog_start_q);
    // empty span, or quotient at or past one: the capped weight
    c_d[0].full       = (fog_end_q <= fog_start_q) || (num >= c_d[0].span);
    c_d[0].region     = b_q.region;
    c_d[0].col        = b_q.hit;
    c_d[0].wt         = '0;
    c_d[0].inc        = b_q.inc;
    for (int i = 1; i <= FOG_STEPS; i++) begin
      c_d[i] = c_q[i-1];
      sh     = {c_q[i-1].rem, 1'b0};
      if (sh >= {1'b0, c_q[i-1].span}) begin
        c_d[i].rem = DEPTH_W'(sh - {1'b0, c_q[i-1].span});
        c_d[i].quo = {c_q[i-1].quo[FOG_STEPS-2:0], 1'b1};
      end else begin
        c_d[i].rem = sh[DEPTH_W-1:0];
        c_d[i].quo = {c_q[i-1].quo[FOG_STEPS-2:0], 1'b0};
      end
      if (i == 1) begin
        idx = c_q[0].inc[INC_W-1] ? WT_W'(WT_ONE) : c_q[0].inc;
        c_d[i].wt = HL_ROM[idx];
      end
      if (i == 2) c_d[i].col = blend(highlight_q, c_q[1].col, c_q[1].wt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= '0;
    else if (en) c_vld_q <= {c_vld_q[FOG_STEPS-1:0], b_vld_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) c_q <= c_d;
  end

  // ---------------- fog weight pick and source colour ----------------
  c_t              c_last;
  logic [WT_W-1:0] cap, qv;
  d_t              d_d, d_q;
  logic            d_vld_q;

  assign c_last = c_q[FOG_STEPS];

  always_comb begin
    cap = fog_limit_q[WT_W-1] ? WT_W'(WT_ONE) : fog_limit_q;
    qv  = WT_W'(c_last.quo);
    d_d.region = c_last.region;
    d_d.src    = (c_last.region == REGION_WALL) ? c_last.col : ground_q;
    if (c_last.zero)      d_d.fw = '0;
    else if (c_last.full) d_d.fw = cap;
    else if (qv > cap)    d_d.fw = cap;
    else                  d_d.fw = qv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= c_vld_q[FOG_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en) d_q <= d_d;
  end

  // ---------------- fog blend and output register ----------------
  logic [RGB_W-1:0] pix_d, pix_q;
  region_e          reg_q;

  assign pix_d = (d_q.region == REGION_SKY) ? sky_q : blend(d_q.src, haze_q, d_q.fw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= d_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q <= pix_d;
      reg_q <= d_q.region;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = pix_q;
  assign m_axis_tuser  = reg_q;

endmodule

// ----- sv/rcfs_checker.sv -----
// ----------------------------------------------------------------------------
// rcfs_sva
// port-level checks of the column shader, bound to the top level
// ----------------------------------------------------------------------------
module rcfs_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rcfs_pkg::OUT_W-1:0]    m_axis_tdata,
  input logic [rcfs_pkg::USER_W-1:0]   m_axis_tuser,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [rcfs_pkg::ADDR_W-1:0]   paddr,
  input logic [rcfs_pkg::DATA_W-1:0]   pwdata,
  input logic [rcfs_pkg::DATA_W-1:0]   prdata,
  input logic                          pready
);
  import rcfs_pkg::*;

  // a waiting pixel stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // input is held back exactly while an output word waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
    else $error("input ready does not follow output stall");

  // an unmapped register reads as zero
  a_unmapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    paddr[ADDR_W-1:2] == 3'd7 |-> prdata == '0)
    else $error("unmapped register read nonzero");

  // a written sky colour register reads back its masked value
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_SKY_RGB
      ##1 paddr == $past(paddr) |-> prdata == DATA_W'($past(pwdata[RGB_W-1:0])))
    else $error("sky colour readback mismatch");

endmodule

bind raycast_column_fog_shader_unit rcfs_sva u_rcfs_sva (.*);
